/* design/cfd_pkg.sv */
// Package for the checksummed frame deframer: sizes, phase and status codes,
// register indexes and the result word type.
// Depends on nothing; the interfaces and the deframer refer to it by scoped names.
`default_nettype none

package cfd_pkg;

   // Payload store depth, the index width that follows from it, and the field widths.
   localparam int MAX_PAYLOAD = 32;
   localparam int IDX_W       = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int ADDR_W      = 24;
   localparam int STATUS_W    = 2;

   // Body byte count saturates at one more than the payload store holds.
   localparam logic [LEN_W-1:0] COUNT_MAX = LEN_W'(MAX_PAYLOAD + 1);
   localparam logic [LEN_W-1:0] STORE_TOP = LEN_W'(MAX_PAYLOAD);

   // Register file of the configuration port.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER = 1'd1;
   localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'h02;
   localparam logic [BYTE_W-1:0] TRAILER_RESET = 8'hFF;

   // Parser phases.
   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_ADDR0 = 3'd1;
   localparam logic [2:0] PH_ADDR1 = 3'd2;
   localparam logic [2:0] PH_ADDR2 = 3'd3;
   localparam logic [2:0] PH_CMD   = 3'd4;
   localparam logic [2:0] PH_BODY  = 3'd5;

   // Frame status codes.
   localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

   // One result word.
   typedef struct packed {
      logic [STATUS_W-1:0] frame_status;
      logic [ADDR_W-1:0]   device_address;
      logic [BYTE_W-1:0]   command_code;
      logic [LEN_W-1:0]    payload_length;
      logic [BYTE_W-1:0]   data_byte;
      logic [IDX_W-1:0]    byte_index;
      logic                last_of_frame;
   } rsp_type;

endpackage

`default_nettype wire

/* design/cfd_if.sv */
// Valid/ready channel interfaces of the deframer: received byte words in,
// result words out. Depends on cfd_pkg for field widths.
`default_nettype none

interface cfd_req_if;
   logic                           valid;
   logic                           ready;
   logic [cfd_pkg::BYTE_W-1:0]     rx_byte;
   logic                           chunk_end;

   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface cfd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cfd_pkg::STATUS_W-1:0]   frame_status;
   logic [cfd_pkg::ADDR_W-1:0]     device_address;
   logic [cfd_pkg::BYTE_W-1:0]     command_code;
   logic [cfd_pkg::LEN_W-1:0]      payload_length;
   logic [cfd_pkg::BYTE_W-1:0]     data_byte;
   logic [cfd_pkg::IDX_W-1:0]      byte_index;
   logic                           last_of_frame;

   modport source (output valid, output frame_status, output device_address,
                   output command_code, output payload_length, output data_byte,
                   output byte_index, output last_of_frame, input ready);
   modport sink   (input valid, input frame_status, input device_address,
                   input command_code, input payload_length, input data_byte,
                   input byte_index, input last_of_frame, output ready);
endinterface

`default_nettype wire

/* design/cfd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used as the payload store of the deframer; no other dependencies.
`default_nettype none

module cfd_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/checksummed_frame_deframer.sv */
// Checksummed frame deframer: parses header, address, command and body bytes,
// emits one result word per good payload byte. Depends on cfd_pkg, cfd_if, cfd_ram.
//
// Use: received bytes enter one word at a time on req_chan (rx_byte, chunk_end).
// A frame is header, three address bytes (high first), a command byte, body
// bytes and the trailer; the last body byte is the additive checksum.
// Results leave on rsp_chan through one output register, so a waiting result
// never blocks the parser while it has nothing else to send.
// New byte words are taken only while the emission sequencer idles. The cycle
// after a closing trailer judges the frame and, for an error or an empty payload,
// loads the single result as soon as the output register is free. For a good
// frame, each payload byte is then read from the payload RAM (registered read
// data) and loaded into the output register once it is free. New bytes are held
// off (req_chan.ready low) until the last result of the frame is loaded. When the
// receiver stalls, the output register holds its word and the emission sequence
// waits on it. Reset (synchronous, active high) returns the parser to hunting,
// restores the header (0x02) and trailer (0xFF) registers and empties the output
// register. The payload RAM needs no clearing: only entries written in the frame
// are read. Configuration (csr_we, csr_index, csr_wdata) is to be written while
// the block idles; this binds the user, as the block does not enforce it.
`default_nettype none

module checksummed_frame_deframer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [cfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cfd_pkg::BYTE_W-1:0]       csr_wdata,
   cfd_req_if.sink                               req_chan,
   cfd_rsp_if.source                             rsp_chan
);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FIN  = 2'd1;
   localparam logic [1:0] S_RD   = 2'd2;
   localparam logic [1:0] S_LD   = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [2:0]                      phase_ff, phase_in;
   logic [cfd_pkg::BYTE_W-1:0]      hdr_ff, trl_ff;
   logic [cfd_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [cfd_pkg::BYTE_W-1:0]      cmd_ff, cmd_in;
   logic [cfd_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic [cfd_pkg::BYTE_W-1:0]      prev_ff, prev_in;
   logic [cfd_pkg::LEN_W-1:0]       count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic [cfd_pkg::IDX_W-1:0]       emit_idx_ff, emit_idx_in;
   logic [cfd_pkg::LEN_W-1:0]       emit_len_ff, emit_len_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cfd_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            accept;
   logic                            slot_free;
   logic                            close_frame;
   logic                            emit_last;
   logic [cfd_pkg::LEN_W-1:0]       body_pos;
   logic                            ram_wr_en;
   logic                            ram_rd_en;
   logic [cfd_pkg::BYTE_W-1:0]      ram_rd_data;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign body_pos  = count_ff - cfd_pkg::LEN_W'(1);
   assign emit_last = (({1'b0, emit_idx_ff}) + cfd_pkg::LEN_W'(1)) == emit_len_ff;

   // A trailer in the body closes the frame unless the body is empty.
   assign close_frame = (phase_ff == cfd_pkg::PH_BODY) && (req_chan.rx_byte == trl_ff)
                        && (count_ff != '0);

   // A body byte pushes the previous one into the store while it still fits.
   assign ram_wr_en = accept && (phase_ff == cfd_pkg::PH_BODY)
                      && (req_chan.rx_byte != trl_ff) && (count_ff != '0)
                      && (count_ff <= cfd_pkg::STORE_TOP);
   assign ram_rd_en = (state_ff == S_RD);

   assign req_chan.ready = (state_ff == S_IDLE);

   cfd_ram #(
      .DEPTH (cfd_pkg::MAX_PAYLOAD),
      .WIDTH (cfd_pkg::BYTE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (body_pos[cfd_pkg::IDX_W-1:0]),
      .wr_data (prev_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (emit_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Parser: one accepted byte word updates the frame state.
   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      cmd_in   = cmd_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         unique case (phase_ff)
            cfd_pkg::PH_HUNT: begin
               if (req_chan.rx_byte == hdr_ff) begin
                  phase_in = cfd_pkg::PH_ADDR0;
                  sum_in   = '0;
                  addr_in  = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
            cfd_pkg::PH_ADDR0, cfd_pkg::PH_ADDR1, cfd_pkg::PH_ADDR2: begin
               addr_in  = {addr_ff[cfd_pkg::ADDR_W-cfd_pkg::BYTE_W-1:0], req_chan.rx_byte};
               sum_in   = sum_ff + req_chan.rx_byte;
               phase_in = phase_ff + 3'd1;
            end
            cfd_pkg::PH_CMD: begin
               cmd_in   = req_chan.rx_byte;
               sum_in   = sum_ff + req_chan.rx_byte;
               count_in = '0;
               ovf_in   = 1'b0;
               phase_in = cfd_pkg::PH_BODY;
            end
            cfd_pkg::PH_BODY: begin
               if (req_chan.rx_byte == trl_ff) begin
                  phase_in = cfd_pkg::PH_HUNT;
               end else begin
                  if (count_ff != '0) begin
                     if (count_ff <= cfd_pkg::STORE_TOP) begin
                        sum_in = sum_ff + prev_ff;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  prev_in = req_chan.rx_byte;
                  if (count_ff < cfd_pkg::COUNT_MAX) begin
                     count_in = count_ff + cfd_pkg::LEN_W'(1);
                  end
               end
            end
            default: begin
               phase_in = cfd_pkg::PH_HUNT;
            end
         endcase
         if (req_chan.chunk_end) begin
            phase_in = cfd_pkg::PH_HUNT;
         end
      end
   end

   // Emission sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      emit_idx_in  = emit_idx_ff;
      emit_len_in  = emit_len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && close_frame) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            emit_idx_in = '0;
            emit_len_in = body_pos;
            if (ovf_ff || (sum_ff != prev_ff) || (body_pos == '0)) begin
               // Error or empty payload: a single closing word.
               if (slot_free) begin
                  rsp_in.device_address = addr_ff;
                  rsp_in.command_code   = cmd_ff;
                  rsp_in.data_byte      = '0;
                  rsp_in.byte_index     = '0;
                  rsp_in.last_of_frame  = 1'b1;
                  priority if (ovf_ff) begin
                     rsp_in.frame_status   = cfd_pkg::ST_OVERFLOW;
                     rsp_in.payload_length = '0;
                  end else if (sum_ff != prev_ff) begin
                     rsp_in.frame_status   = cfd_pkg::ST_BAD_SUM;
                     rsp_in.payload_length = body_pos;
                  end else begin
                     rsp_in.frame_status   = cfd_pkg::ST_GOOD;
                     rsp_in.payload_length = '0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_LD;
         end
         S_LD: begin
            if (slot_free) begin
               rsp_in.frame_status   = cfd_pkg::ST_GOOD;
               rsp_in.device_address = addr_ff;
               rsp_in.command_code   = cmd_ff;
               rsp_in.payload_length = emit_len_ff;
               rsp_in.data_byte      = ram_rd_data;
               rsp_in.byte_index     = emit_idx_ff;
               rsp_in.last_of_frame  = emit_last;
               rsp_valid_in          = 1'b1;
               emit_idx_in           = emit_idx_ff + cfd_pkg::IDX_W'(1);
               state_in              = emit_last ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= cfd_pkg::PH_HUNT;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         addr_ff      <= '0;
         cmd_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         hdr_ff       <= cfd_pkg::HEADER_RESET;
         trl_ff       <= cfd_pkg::TRAILER_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         addr_ff      <= addr_in;
         cmd_ff       <= cmd_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               cfd_pkg::CSR_HEADER:  hdr_ff <= csr_wdata;
               cfd_pkg::CSR_TRAILER: trl_ff <= csr_wdata;
               default:              hdr_ff <= hdr_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      emit_idx_ff <= emit_idx_in;
      emit_len_ff <= emit_len_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.frame_status   = rsp_ff.frame_status;
   assign rsp_chan.device_address = rsp_ff.device_address;
   assign rsp_chan.command_code   = rsp_ff.command_code;
   assign rsp_chan.payload_length = rsp_ff.payload_length;
   assign rsp_chan.data_byte      = rsp_ff.data_byte;
   assign rsp_chan.byte_index     = rsp_ff.byte_index;
   assign rsp_chan.last_of_frame  = rsp_ff.last_of_frame;

   // The body count never passes its saturation point.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cfd_pkg::COUNT_MAX)
      else $error("body count beyond saturation");

   // Overflow is only flagged once the count has saturated.
   a_ovf_count: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == cfd_pkg::COUNT_MAX))
      else $error("overflow flagged without a saturated count");

   // Every RAM read stays inside the payload of the frame.
   a_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (({1'b0, emit_idx_ff}) < emit_len_ff))
      else $error("payload read beyond frame length");

   // A closing trailer always hands the frame to the finish step.
   a_close_to_fin: assert property (@(posedge clock) disable iff (reset)
      (accept && close_frame) |=> (state_ff == S_FIN))
      else $error("closed frame not judged");

endmodule

`default_nettype wire

/* tb/checksummed_frame_deframer_tb.sv */
// Self-checking testbench for the checksummed frame deframer: byte words in,
// frame result words out. Depends on cfd_pkg, cfd_if and the deframer itself.
`default_nettype none

module checksummed_frame_deframer_tb;

   localparam int PERIOD        = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int SEG_COUNT     = 6;
   localparam int SEG_BYTES     = 20;

   // One byte word on the request side, with an optional typed-in result.
   typedef struct packed {
      logic [cfd_pkg::BYTE_W-1:0] rx;
      logic                       ce;
      logic                       typed;
      cfd_pkg::rsp_type           want;
   } rx_word_type;

   localparam cfd_pkg::rsp_type NO_RSP = '0;

   // Directed words: header inside the address, trailer inside address and command,
   // header inside the body, chunk end on a trailer and mid-frame, empty body.
   localparam rx_word_type DIRECTED_WORDS [23] = '{
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b1,
        '{cfd_pkg::ST_GOOD, 24'h020000, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1}},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b1, 1'b1,
        '{cfd_pkg::ST_BAD_SUM, 24'hFFFFFF, 8'hFF, 6'd1, 8'h00, 5'd0, 1'b1}},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'h5A, 1'b1, 1'b0, NO_RSP},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b0, NO_RSP},
      '{8'h02, 1'b0, 1'b0, NO_RSP},
      '{8'h03, 1'b0, 1'b0, NO_RSP},
      '{8'h04, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP}
   };

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [cfd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cfd_pkg::BYTE_W-1:0]    csr_wdata;

   cfd_req_if req_bus ();
   cfd_rsp_if rsp_bus ();

   checksummed_frame_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Parser state and registers mirrored by the testbench.
   logic [cfd_pkg::BYTE_W-1:0] header_val  = cfd_pkg::HEADER_RESET;
   logic [cfd_pkg::BYTE_W-1:0] trailer_val = cfd_pkg::TRAILER_RESET;
   logic [2:0]                 parse_phase = cfd_pkg::PH_HUNT;
   logic [cfd_pkg::ADDR_W-1:0] addr_acc    = '0;
   logic [cfd_pkg::BYTE_W-1:0] cmd_byte    = '0;
   logic [cfd_pkg::BYTE_W-1:0] sum_acc     = '0;
   logic [cfd_pkg::BYTE_W-1:0] held_byte   = '0;
   logic [cfd_pkg::LEN_W-1:0]  body_cnt    = '0;
   logic                       overflow    = 1'b0;
   logic [cfd_pkg::BYTE_W-1:0] payload_mem [cfd_pkg::MAX_PAYLOAD];

   cfd_pkg::rsp_type step_results[$];
   cfd_pkg::rsp_type awaited_results[$];
   rx_word_type      rx_plan[$];

   int   mismatch_count = 0;
   int   cycle_count    = 0;
   int   send_idle_pct  = 0;
   int   recv_idle_pct  = 0;
   int   hold_left      = 0;
   logic hold_req       = 1'b0;
   logic hold_seen      = 1'b0;

   // Advance the mirrored parser by one byte; results land in step_results.
   task automatic parse_rx_byte(input logic [cfd_pkg::BYTE_W-1:0] rx, input logic ce);
      cfd_pkg::rsp_type          r;
      logic [cfd_pkg::LEN_W-1:0] plen;
      int                        i;
      step_results.delete();
      case (parse_phase)
         cfd_pkg::PH_HUNT: begin
            if (rx == header_val) begin
               parse_phase = cfd_pkg::PH_ADDR0;
               sum_acc     = '0;
               addr_acc    = '0;
               body_cnt    = '0;
               overflow    = 1'b0;
            end
         end
         cfd_pkg::PH_ADDR0, cfd_pkg::PH_ADDR1, cfd_pkg::PH_ADDR2: begin
            addr_acc    = {addr_acc[cfd_pkg::ADDR_W-cfd_pkg::BYTE_W-1:0], rx};
            sum_acc     = sum_acc + rx;
            parse_phase = parse_phase + 3'd1;
         end
         cfd_pkg::PH_CMD: begin
            cmd_byte    = rx;
            sum_acc     = sum_acc + rx;
            body_cnt    = '0;
            overflow    = 1'b0;
            parse_phase = cfd_pkg::PH_BODY;
         end
         cfd_pkg::PH_BODY: begin
            if (rx == trailer_val) begin
               // Judge the frame; an empty body gives nothing.
               if (body_cnt != 0) begin
                  plen             = body_cnt - 6'd1;
                  r.device_address = addr_acc;
                  r.command_code   = cmd_byte;
                  r.data_byte      = '0;
                  r.byte_index     = '0;
                  r.last_of_frame  = 1'b1;
                  if (overflow) begin
                     r.frame_status   = cfd_pkg::ST_OVERFLOW;
                     r.payload_length = '0;
                     step_results.push_back(r);
                  end else if (sum_acc != held_byte) begin
                     r.frame_status   = cfd_pkg::ST_BAD_SUM;
                     r.payload_length = plen;
                     step_results.push_back(r);
                  end else if (plen == 0) begin
                     r.frame_status   = cfd_pkg::ST_GOOD;
                     r.payload_length = '0;
                     step_results.push_back(r);
                  end else begin
                     for (i = 0; i < plen; i++) begin
                        r.frame_status   = cfd_pkg::ST_GOOD;
                        r.payload_length = plen;
                        r.data_byte      = payload_mem[i[cfd_pkg::IDX_W-1:0]];
                        r.byte_index     = i[cfd_pkg::IDX_W-1:0];
                        r.last_of_frame  = (i == plen - 1);
                        step_results.push_back(r);
                     end
                  end
               end
               parse_phase = cfd_pkg::PH_HUNT;
            end else begin
               // The byte before this one was payload, not the checksum.
               if (body_cnt != 0) begin
                  if (body_cnt <= cfd_pkg::STORE_TOP) begin
                     payload_mem[cfd_pkg::IDX_W'(body_cnt - 6'd1)] = held_byte;
                     sum_acc = sum_acc + held_byte;
                  end else begin
                     overflow = 1'b1;
                  end
               end
               held_byte = rx;
               if (body_cnt < cfd_pkg::COUNT_MAX)
                  body_cnt = body_cnt + 6'd1;
            end
         end
         default: parse_phase = cfd_pkg::PH_HUNT;
      endcase
      if (ce)
         parse_phase = cfd_pkg::PH_HUNT;
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] seen,
                              input logic [31:0] want);
      if (seen !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, want));
   endtask

   // Offer one byte word, wait for it to be taken, then record what it causes.
   task automatic send_word(input rx_word_type w);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.rx_byte   <= w.rx;
      req_bus.chunk_end <= w.ce;
      do begin
         @(negedge clock);
         taken = (req_bus.ready === 1'b1);
         @(posedge clock);
      end while (!taken);
      parse_rx_byte(w.rx, w.ce);
      if (w.typed)
         awaited_results.push_back(w.want);
      else
         foreach (step_results[k])
            awaited_results.push_back(step_results[k]);
   endtask

   task automatic write_reg(input logic [cfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cfd_pkg::BYTE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         cfd_pkg::CSR_HEADER:  header_val  = value;
         cfd_pkg::CSR_TRAILER: trailer_val = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Wait for every awaited result, then let a frame that gives none settle.
   task automatic drain_results();
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Plan one frame under the current header and trailer; returns its word count.
   function automatic int plan_frame(input int plen, input bit bad_sum, input bit no_body,
                                     input bit ce_last, input int cut_at);
      logic [cfd_pkg::BYTE_W-1:0] bytes[$];
      logic [cfd_pkg::BYTE_W-1:0] sum;
      logic [cfd_pkg::BYTE_W-1:0] b;
      rx_word_type                w;
      int                         i;
      sum = '0;
      bytes.push_back(header_val);
      for (i = 0; i < 4; i++) begin
         b = 8'($urandom_range(255));
         bytes.push_back(b);
         sum = sum + b;
      end
      if (!no_body) begin
         for (i = 0; i < plen; i++) begin
            b = 8'($urandom_range(255));
            if (b == trailer_val)
               b = b ^ 8'h80;
            bytes.push_back(b);
            sum = sum + b;
         end
         if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
         bytes.push_back(sum);
      end
      bytes.push_back(trailer_val);
      for (i = 0; i < bytes.size(); i++) begin
         w.rx    = bytes[i];
         w.ce    = (i == cut_at) || (ce_last && i == bytes.size() - 1);
         w.typed = 1'b0;
         w.want  = NO_RSP;
         rx_plan.push_back(w);
         if (i == cut_at)
            return i + 1;
      end
      return bytes.size();
   endfunction

   // Mostly well-formed frames with random content, some noise and broken frames.
   task automatic plan_random_frames(input int budget, input int forced_len);
      int          used;
      int          pick;
      int          plen;
      int          cut;
      rx_word_type w;
      used = 0;
      if (forced_len >= 0)
         used += plan_frame(forced_len, 1'b0, 1'b0, 1'b0, -1);
      while (used < budget) begin
         if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(1, 3)) begin
               w.rx = 8'($urandom_range(255));
               if (w.rx == header_val)
                  w.rx = w.rx ^ 8'h01;
               w.ce    = ($urandom_range(7) == 0);
               w.typed = 1'b0;
               w.want  = NO_RSP;
               rx_plan.push_back(w);
            end
         end
         pick = $urandom_range(99);
         if (pick < 80)
            plen = $urandom_range(0, 3);
         else if (pick < 94)
            plen = $urandom_range(4, 12);
         else if (pick < 97)
            plen = cfd_pkg::MAX_PAYLOAD;
         else
            plen = cfd_pkg::MAX_PAYLOAD + 1;
         cut = ($urandom_range(99) < 6) ? $urandom_range(0, plen + 5) : -1;
         used += plan_frame(plen, $urandom_range(99) < 10, $urandom_range(99) < 5,
                            $urandom_range(99) < 12, cut);
      end
   endtask

   // Receiver: random stalls, and a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_seen     <= hold_req;
      end else if (hold_req != hold_seen) begin
         hold_seen     <= hold_req;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare every result word taken with the oldest awaited one.
   always @(negedge clock) begin : result_check
      cfd_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result word with none awaited, status %0d",
                                      rsp_bus.frame_status));
         end else begin
            want = awaited_results.pop_front();
            check_field("frame_status", 32'(rsp_bus.frame_status),
                        32'(want.frame_status));
            check_field("device_address", 32'(rsp_bus.device_address),
                        32'(want.device_address));
            check_field("command_code", 32'(rsp_bus.command_code),
                        32'(want.command_code));
            check_field("payload_length", 32'(rsp_bus.payload_length),
                        32'(want.payload_length));
            check_field("data_byte", 32'(rsp_bus.data_byte), 32'(want.data_byte));
            check_field("byte_index", 32'(rsp_bus.byte_index), 32'(want.byte_index));
            check_field("last_of_frame", 32'(rsp_bus.last_of_frame),
                        32'(want.last_of_frame));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int                         seg;
      logic [cfd_pkg::BYTE_W-1:0] hdr;
      logic [cfd_pkg::BYTE_W-1:0] trl;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= cfd_pkg::CSR_HEADER;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= '0;
      req_bus.chunk_end <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words run on the reset register values.
      send_idle_pct = 36;
      recv_idle_pct <= 73;
      foreach (DIRECTED_WORDS[i])
         send_word(DIRECTED_WORDS[i]);
      req_bus.valid <= 1'b0;

      // Random segments, each under its own header and trailer.
      for (seg = 0; seg < SEG_COUNT; seg++) begin
         drain_results();
         case (seg)
            0: begin hdr = 8'h00; trl = 8'hFF; end
            1: begin hdr = 8'hFF; trl = 8'h00; end
            3: begin hdr = 8'h7E; trl = 8'h7E; end
            5: begin hdr = cfd_pkg::HEADER_RESET; trl = cfd_pkg::TRAILER_RESET; end
            default: begin
               hdr = 8'($urandom_range(255));
               trl = 8'($urandom_range(255));
            end
         endcase
         write_reg(cfd_pkg::CSR_HEADER, hdr);
         write_reg(cfd_pkg::CSR_TRAILER, trl);
         if (seg < 2) begin
            send_idle_pct = 36;
            recv_idle_pct <= 73;
         end else if (seg < 4) begin
            send_idle_pct = 73;
            recv_idle_pct <= 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         // The last segment opens with a full payload under a long receiver hold-off.
         if (seg == SEG_COUNT - 1)
            hold_req <= ~hold_req;
         rx_plan.delete();
         plan_random_frames(SEG_BYTES, (seg == 1) ? cfd_pkg::MAX_PAYLOAD + 1 :
                                       (seg == SEG_COUNT - 1) ? cfd_pkg::MAX_PAYLOAD : -1);
         foreach (rx_plan[i])
            send_word(rx_plan[i]);
         req_bus.valid <= 1'b0;
      end

      drain_results();
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
